>>> rtl/core/dtf_pkg.sv
// shared types, constants and float helpers for the decimal text to float32 converter
// no dependencies; imported by every module of the block
`default_nettype none

package dtf_pkg;

    localparam int MAX_FRAC_DIGITS_DEFAULT = 19;
    localparam int DEN_COUNT = 19;
    localparam int POS_W = 5;

    typedef logic [POS_W-1:0] frac_pos_t;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_POINT  = 8'h2E;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    localparam logic [1:0] ST_SEP     = 2'd0;
    localparam logic [1:0] ST_EOI     = 2'd1;
    localparam logic [1:0] ST_BRACKET = 2'd2;
    localparam logic [1:0] ST_ERROR   = 2'd3;

    localparam logic [31:0] FP_POS_INF = 32'h7F80_0000;
    localparam logic [31:0] FP_ZERO    = 32'h0000_0000;

    typedef struct packed {
        logic [7:0] source_char;
        logic       starts_token;
        logic       inside_brackets;
    } dtf_in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] end_status;
        logic       last_of_run;
    } dtf_out_t;

    typedef enum logic [2:0] {
        OP_LOAD,
        OP_INT,
        OP_FRAC,
        OP_EMIT,
        OP_ERROR
    } dtf_op_t;

    typedef struct packed {
        dtf_op_t    op;
        logic [3:0] digit;
        frac_pos_t  pos;
        logic [1:0] status;
        logic       neg;
    } dtf_cmd_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_ADD,
        B_DIV,
        B_EMIT
    } dtf_back_state_t;

    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_RUN,
        DIV_ROUND
    } dtf_div_state_t;

    typedef logic [31:0] den_table_t [0:DEN_COUNT-1];

    // round to nearest even and pack a positive value, overflow goes to infinity
    function automatic logic [31:0] fp_round(input logic [9:0] exp_in, input logic [23:0] mant,
                                             input logic guard, input logic sticky);
        logic [24:0] sum;
        logic [9:0]  e;
        logic [22:0] frac;
        sum = {1'b0, mant} + 25'(guard & (sticky | mant[0]));
        if (sum[24])
        begin
            e    = exp_in + 10'd1;
            frac = 23'd0;
        end
        else
        begin
            e    = exp_in;
            frac = sum[22:0];
        end
        if (e >= 10'd255)
            return FP_POS_INF;
        return {1'b0, e[7:0], frac};
    endfunction

    // elaboration only: integer to single with nearest-even rounding
    function automatic logic [31:0] u64_to_float(input logic [63:0] v);
        int          lp;
        int          sh;
        logic [23:0] mant;
        logic        g;
        logic        st;
        lp = 0;
        for (int i = 0; i < 64; i++)
            if (v[i])
                lp = i;
        if (v == 64'd0)
            return FP_ZERO;
        if (lp <= 23)
        begin
            mant = 24'(v << (23 - lp));
            return fp_round(10'(127 + lp), mant, 1'b0, 1'b0);
        end
        sh   = lp - 23;
        mant = 24'(v >> sh);
        g    = v[sh-1];
        st   = (v & ((64'd1 << (sh - 1)) - 64'd1)) != 64'd0;
        return fp_round(10'(127 + lp), mant, g, st);
    endfunction

    function automatic den_table_t build_den_table();
        den_table_t  t;
        logic [63:0] p;
        p = 64'd1;
        for (int i = 0; i < DEN_COUNT; i++)
        begin
            p    = p * 64'd10;
            t[i] = u64_to_float(p);
        end
        return t;
    endfunction

    // single value of ten to the power index+1
    localparam den_table_t DEN_TABLE = build_den_table();

    function automatic logic [31:0] int_to_float(input logic [3:0] d);
        logic [1:0]  p;
        logic [23:0] mant;
        if (d[3])
            p = 2'd3;
        else if (d[2])
            p = 2'd2;
        else if (d[1])
            p = 2'd1;
        else
            p = 2'd0;
        mant = {d, 20'd0} << (2'd3 - p);
        if (d == 4'd0)
            return FP_ZERO;
        return {1'b0, 8'(8'd127 + 8'(p)), mant[22:0]};
    endfunction

    // times ten for zero, normal or infinite positive values
    function automatic logic [31:0] fp_mul10(input logic [31:0] a);
        logic [23:0] m;
        logic [27:0] prod;
        if (a[30:23] == 8'hFF)
            return FP_POS_INF;
        if (a[30:23] == 8'h00)
            return FP_ZERO;
        m    = {1'b1, a[22:0]};
        prod = {1'b0, m, 3'b000} + {3'b000, m, 1'b0};
        if (prod[27])
            return fp_round(10'(a[30:23]) + 10'd4, prod[27:4], prod[3], |prod[2:0]);
        return fp_round(10'(a[30:23]) + 10'd3, prod[26:3], prod[2], |prod[1:0]);
    endfunction

    // sum of two positive values (zero, normal or infinity)
    function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] x;
        logic [31:0] y;
        logic [7:0]  diff;
        logic [26:0] mx;
        logic [26:0] my;
        logic [26:0] ya;
        logic        st;
        logic [27:0] sum;
        if (a[30:23] == 8'hFF || b[30:23] == 8'hFF)
            return FP_POS_INF;
        if (a[30:23] == 8'h00)
            return b;
        if (b[30:23] == 8'h00)
            return a;
        if (b[30:23] > a[30:23])
        begin
            x = b;
            y = a;
        end
        else
        begin
            x = a;
            y = b;
        end
        diff = x[30:23] - y[30:23];
        mx   = {1'b1, x[22:0], 3'b000};
        my   = {1'b1, y[22:0], 3'b000};
        if (diff >= 8'd27)
        begin
            ya = 27'd0;
            st = 1'b1;
        end
        else
        begin
            ya = my >> diff;
            st = (my & ((27'd1 << diff) - 27'd1)) != 27'd0;
        end
        ya[0] = ya[0] | st;
        sum   = {1'b0, mx} + {1'b0, ya};
        if (sum[27])
            return fp_round(10'(x[30:23]) + 10'd1, sum[27:4], sum[3], |sum[2:0]);
        return fp_round(10'(x[30:23]), sum[26:3], sum[2], |sum[1:0]);
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/dtf_front.sv
// front end: takes characters, tracks token state and turns them into back end commands
// depends on dtf_pkg
`default_nettype none

module dtf_front #(
    parameter int MAX_FRACTION_DIGITS = dtf_pkg::MAX_FRAC_DIGITS_DEFAULT
) (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                char_valid,
    output logic               char_ready,
    input  dtf_pkg::dtf_in_t   char_data,
    output logic               push,
    output dtf_pkg::dtf_cmd_t  push_cmd,
    input  wire                q_full
);
    import dtf_pkg::*;

    logic      active_reg, active_next;
    logic      frac_reg, frac_next;
    logic      neg_reg, neg_next;
    frac_pos_t pos_reg, pos_next;

    logic       accept;
    logic [7:0] c;
    logic       is_digit;
    logic [3:0] digit;

    assign char_ready = !q_full;
    assign accept     = char_valid && char_ready;
    assign c          = char_data.source_char;
    assign is_digit   = (c >= CH_ZERO) && (c <= CH_NINE);
    assign digit      = 4'(c - CH_ZERO);

    always_comb
    begin
        active_next = active_reg;
        frac_next   = frac_reg;
        neg_next    = neg_reg;
        pos_next    = pos_reg;
        push        = 1'b0;
        push_cmd    = '{op: OP_LOAD, digit: digit, pos: pos_reg, status: ST_SEP, neg: neg_reg};
        if (accept)
        begin
            priority if (char_data.starts_token)
            begin
                frac_next = 1'b0;
                pos_next  = frac_pos_t'(1);
                push      = 1'b1;
                if (c == CH_MINUS || is_digit)
                begin
                    active_next    = 1'b1;
                    neg_next       = (c == CH_MINUS);
                    push_cmd.digit = (c == CH_MINUS) ? 4'd0 : digit;
                end
                else
                begin
                    active_next     = 1'b0;
                    neg_next        = 1'b0;
                    push_cmd.op     = OP_ERROR;
                    push_cmd.status = ST_ERROR;
                end
            end
            else if (!active_reg)
            begin
                // nothing in progress, character dropped
            end
            else if (is_digit)
            begin
                if (!frac_reg)
                begin
                    push        = 1'b1;
                    push_cmd.op = OP_INT;
                end
                else if (pos_reg <= POS_W'(MAX_FRACTION_DIGITS))
                begin
                    push        = 1'b1;
                    push_cmd.op = OP_FRAC;
                    pos_next    = pos_reg + frac_pos_t'(1);
                end
            end
            else if (c == CH_POINT && !frac_reg)
            begin
                frac_next = 1'b1;
            end
            else
            begin
                push        = 1'b1;
                active_next = 1'b0;
                frac_next   = 1'b0;
                neg_next    = 1'b0;
                pos_next    = frac_pos_t'(1);
                push_cmd.op = OP_EMIT;
                if (c == CH_SPACE || c == CH_LF || c == CH_CR)
                    push_cmd.status = ST_SEP;
                else if (c == CH_RPAREN && char_data.inside_brackets)
                    push_cmd.status = ST_BRACKET;
                else if (c == CH_NUL)
                    push_cmd.status = ST_EOI;
                else
                begin
                    push_cmd.op     = OP_ERROR;
                    push_cmd.status = ST_ERROR;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            frac_reg   <= 1'b0;
            neg_reg    <= 1'b0;
            pos_reg    <= frac_pos_t'(1);
        end
        else
        begin
            active_reg <= active_next;
            frac_reg   <= frac_next;
            neg_reg    <= neg_next;
            pos_reg    <= pos_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/dtf_cmd_queue.sv
// two-slot command queue between front and back end
// depends on dtf_pkg
`default_nettype none

module dtf_cmd_queue (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                push,
    input  dtf_pkg::dtf_cmd_t  push_cmd,
    output logic               full,
    input  wire                pop,
    output logic               q_valid,
    output dtf_pkg::dtf_cmd_t  q_cmd
);
    import dtf_pkg::*;

    dtf_cmd_t   slot_reg [0:1];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full    = (count_reg == 2'd2);
    assign q_valid = (count_reg != 2'd0);
    assign q_cmd   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/dtf_fp_divider.sv
// radix-2 restoring divider: small digit over a power-of-ten single, rounded to single
// depends on dtf_pkg
`default_nettype none

module dtf_fp_divider (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         start,
    input  wire [3:0]   digit,
    input  wire [31:0]  den,
    output logic        done,
    output logic [31:0] quot
);
    import dtf_pkg::*;

    localparam int QUO_BITS = 31;
    localparam int CNT_W    = $clog2(QUO_BITS);

    dtf_div_state_t      state_reg, state_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [23:0]         rem_reg, rem_next;
    logic [QUO_BITS-1:0] quo_reg, quo_next;
    logic [23:0]         dm_reg, dm_next;
    logic [7:0]          de_reg, de_next;

    logic [24:0] r2;
    logic        ge;

    logic [23:0] n_mant;
    logic        n_guard;
    logic        n_sticky;
    logic [9:0]  n_lead;

    assign r2 = {rem_reg, 1'b0};
    assign ge = (r2 >= {1'b0, dm_reg});

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            DIV_IDLE:  if (start) state_next = DIV_RUN;
            DIV_RUN:   if (cnt_reg == CNT_W'(QUO_BITS - 1)) state_next = DIV_ROUND;
            DIV_ROUND: state_next = DIV_IDLE;
            default:   state_next = DIV_IDLE;
        endcase
    end

    // datapath
    always_comb
    begin
        cnt_next = cnt_reg;
        rem_next = rem_reg;
        quo_next = quo_reg;
        dm_next  = dm_reg;
        de_next  = de_reg;
        unique case (state_reg)
            DIV_IDLE:
            begin
                if (start)
                begin
                    cnt_next = '0;
                    rem_next = {1'b0, digit, 19'd0};
                    quo_next = '0;
                    dm_next  = {1'b1, den[22:0]};
                    de_next  = den[30:23];
                end
            end
            DIV_RUN:
            begin
                cnt_next = cnt_reg + CNT_W'(1);
                rem_next = ge ? 24'(r2 - {1'b0, dm_reg}) : r2[23:0];
                quo_next = {quo_reg[QUO_BITS-2:0], ge};
            end
            default:
            begin
            end
        endcase
    end

    // normalise: leading one sits in the top five quotient bits
    always_comb
    begin
        priority if (quo_reg[30])
        begin
            n_mant = quo_reg[30:7]; n_guard = quo_reg[6]; n_sticky = |quo_reg[5:0]; n_lead = 10'd30;
        end
        else if (quo_reg[29])
        begin
            n_mant = quo_reg[29:6]; n_guard = quo_reg[5]; n_sticky = |quo_reg[4:0]; n_lead = 10'd29;
        end
        else if (quo_reg[28])
        begin
            n_mant = quo_reg[28:5]; n_guard = quo_reg[4]; n_sticky = |quo_reg[3:0]; n_lead = 10'd28;
        end
        else if (quo_reg[27])
        begin
            n_mant = quo_reg[27:4]; n_guard = quo_reg[3]; n_sticky = |quo_reg[2:0]; n_lead = 10'd27;
        end
        else
        begin
            n_mant = quo_reg[26:3]; n_guard = quo_reg[2]; n_sticky = |quo_reg[1:0]; n_lead = 10'd26;
        end
    end

    // outputs
    always_comb
    begin
        done = (state_reg == DIV_ROUND);
        quot = fp_round(n_lead - {2'b00, de_reg} + 10'd227, n_mant, n_guard,
                        n_sticky | (rem_reg != 24'd0));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= DIV_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dm_reg  <= dm_next;
        de_reg  <= de_next;
    end

endmodule

`default_nettype wire

>>> rtl/core/dtf_back.sv
// back end: float accumulator, digit arithmetic and result beat sequencing
// depends on dtf_pkg and dtf_fp_divider
`default_nettype none

module dtf_back (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                q_valid,
    input  dtf_pkg::dtf_cmd_t  q_cmd,
    output logic               pop,
    input  wire [7:0]          number_type_tag,
    output logic               res_valid,
    input  wire                res_ready,
    output dtf_pkg::dtf_out_t  res_data
);
    import dtf_pkg::*;

    localparam logic [2:0] BEAT_LAST = 3'd4;

    dtf_back_state_t state_reg, state_next;
    logic [31:0] acc_reg, acc_next;
    logic [31:0] opa_reg, opa_next;
    logic [31:0] opb_reg, opb_next;
    logic [2:0]  beat_reg, beat_next;
    logic        err_reg, err_next;
    logic        neg_reg, neg_next;
    logic [1:0]  status_reg, status_next;
    logic        res_valid_reg, res_valid_next;
    dtf_out_t    res_data_reg, res_data_next;

    logic        slot_free;
    logic        div_start;
    logic        div_done;
    logic [31:0] div_quot;
    logic [31:0] den;
    logic [31:0] bits;
    logic [4:0]  den_idx;

    assign slot_free = !res_valid_reg || res_ready;
    assign pop       = (state_reg == B_IDLE) && q_valid;
    assign den_idx   = 5'(q_cmd.pos - frac_pos_t'(1));
    assign den       = DEN_TABLE[den_idx];
    assign bits      = acc_reg ^ {neg_reg, 31'd0};
    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

    dtf_fp_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .digit (q_cmd.digit),
        .den   (den),
        .done  (div_done),
        .quot  (div_quot)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                if (q_valid)
                begin
                    unique case (q_cmd.op)
                        OP_INT:   state_next = B_ADD;
                        OP_FRAC:  if (q_cmd.digit != 4'd0) state_next = B_DIV;
                        OP_EMIT:  state_next = B_EMIT;
                        OP_ERROR: state_next = B_EMIT;
                        default:  state_next = B_IDLE;
                    endcase
                end
            end
            B_DIV:   if (div_done) state_next = B_ADD;
            B_ADD:   state_next = B_IDLE;
            B_EMIT:  if (slot_free && (err_reg || beat_reg == BEAT_LAST)) state_next = B_IDLE;
            default: state_next = B_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        acc_next       = acc_reg;
        opa_next       = opa_reg;
        opb_next       = opb_reg;
        beat_next      = beat_reg;
        err_next       = err_reg;
        neg_next       = neg_reg;
        status_next    = status_reg;
        res_valid_next = res_valid_reg && !res_ready;
        res_data_next  = res_data_reg;
        div_start      = 1'b0;
        unique case (state_reg)
            B_IDLE:
            begin
                if (q_valid)
                begin
                    unique case (q_cmd.op)
                        OP_LOAD: acc_next = int_to_float(q_cmd.digit);
                        OP_INT:
                        begin
                            opa_next = fp_mul10(acc_reg);
                            opb_next = int_to_float(q_cmd.digit);
                        end
                        OP_FRAC: div_start = (q_cmd.digit != 4'd0);
                        OP_EMIT, OP_ERROR:
                        begin
                            err_next    = (q_cmd.op == OP_ERROR);
                            neg_next    = q_cmd.neg;
                            status_next = q_cmd.status;
                            beat_next   = 3'd0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            B_DIV:
            begin
                if (div_done)
                begin
                    opa_next = acc_reg;
                    opb_next = div_quot;
                end
            end
            B_ADD: acc_next = fp_add(opa_reg, opb_reg);
            B_EMIT:
            begin
                if (slot_free)
                begin
                    res_valid_next           = 1'b1;
                    res_data_next.end_status = status_reg;
                    beat_next                = beat_reg + 3'd1;
                    if (err_reg)
                    begin
                        res_data_next.out_byte    = 8'd0;
                        res_data_next.last_of_run = 1'b1;
                    end
                    else
                    begin
                        res_data_next.last_of_run = (beat_reg == BEAT_LAST);
                        unique case (beat_reg)
                            3'd0:    res_data_next.out_byte = number_type_tag;
                            3'd1:    res_data_next.out_byte = bits[7:0];
                            3'd2:    res_data_next.out_byte = bits[15:8];
                            3'd3:    res_data_next.out_byte = bits[23:16];
                            default: res_data_next.out_byte = bits[31:24];
                        endcase
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            acc_reg       <= FP_ZERO;
            beat_reg      <= 3'd0;
            err_reg       <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            acc_reg       <= acc_next;
            beat_reg      <= beat_next;
            err_reg       <= err_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        opa_reg      <= opa_next;
        opb_reg      <= opb_next;
        neg_reg      <= neg_next;
        status_reg   <= status_next;
        res_data_reg <= res_data_next;
    end

`ifndef ASSERT_OFF
    a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == B_DIV)
        else $error("divider finished while back end was not waiting");

    a_error_beat: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_data_reg.end_status == ST_ERROR
            |-> res_data_reg.last_of_run && res_data_reg.out_byte == 8'd0)
        else $error("error beat is not a single zero beat");

    a_beat_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == B_EMIT |-> beat_reg <= BEAT_LAST)
        else $error("beat counter ran past the last float byte");
`endif

endmodule

`default_nettype wire

>>> rtl/core/decimal_text_to_float32.sv
// top level of the decimal text to single precision converter
// depends on dtf_pkg, dtf_front, dtf_cmd_queue, dtf_back
`default_nettype none

// Converts number tokens, one source character per beat, into IEEE single values.
// Integer digits are folded in with a rounded multiply by ten and a rounded add; each
// fraction digit adds digit / float(10^k). A front end takes a character every cycle
// while its two-slot command queue has room, tracks sign, point and fraction position,
// and drops characters outside a token. The back end works through the commands: a
// start digit loads the accumulator, an integer digit is multiplied by ten and then
// added, a nonzero fraction digit runs the radix-2 divider (start, 31 quotient steps,
// one rounding step) and then adds the quotient, and a zero fraction digit adds nothing.
// A terminator produces five beats (type tag, then the float bytes least significant
// first) and a bad character one zero beat with error status; the output register lets
// the next characters queue up while a beat waits. The tag register is written through
// cfg_we and cfg_data, by the user only while the block is idle; this is not enforced.
module decimal_text_to_float32 #(
    parameter int MAX_FRACTION_DIGITS = dtf_pkg::MAX_FRAC_DIGITS_DEFAULT
) (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                char_valid,
    output logic               char_ready,
    input  dtf_pkg::dtf_in_t   char_data,
    output logic               res_valid,
    input  wire                res_ready,
    output dtf_pkg::dtf_out_t  res_data,
    input  wire                cfg_we,
    input  wire [7:0]          cfg_data
);
    import dtf_pkg::*;

    // number type tag, first beat of every number
    logic [7:0] tag_reg, tag_next;

    logic     push;
    dtf_cmd_t push_cmd;
    logic     q_full;
    logic     q_valid;
    dtf_cmd_t q_cmd;
    logic     pop;

    assign tag_next = cfg_we ? cfg_data : tag_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tag_reg <= 8'd0;
        else
            tag_reg <= tag_next;
    end

    // character classification and token tracking
    dtf_front #(
        .MAX_FRACTION_DIGITS (MAX_FRACTION_DIGITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_valid (char_valid),
        .char_ready (char_ready),
        .char_data  (char_data),
        .push       (push),
        .push_cmd   (push_cmd),
        .q_full     (q_full)
    );

    // decouples the per-character front from the back end arithmetic
    dtf_cmd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (pop),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd)
    );

    // float arithmetic and result beats
    dtf_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .q_valid         (q_valid),
        .q_cmd           (q_cmd),
        .pop             (pop),
        .number_type_tag (tag_reg),
        .res_valid       (res_valid),
        .res_ready       (res_ready),
        .res_data        (res_data)
    );

endmodule

`default_nettype wire
